// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level RTL file of the sorted id index table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/sidt_pkg.sv =====
// Types and constants of the sorted id index table.
package sidt_pkg;

  localparam int ID_W     = 16;
  localparam int SIZE_W   = 17;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 17'h10000;  // 64 KiB

  localparam logic OP_UPSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

// ===== rtl/sidt_mem.sv =====
// Entry memory: one write port, one read port, registered read data.
module sidt_mem #(
  parameter int DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  sidt_pkg::entry_t           wr_data_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output sidt_pkg::entry_t           rd_data_o
);
  import sidt_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/sorted_id_index_table_top.sv =====
// Top level of the sorted id index table: request sequencer around the entry memory.
//
//  channel   dir  handshake                 payload
//  --------  ---  ------------------------  ------------------------------------
//  cfg       in   cfg_we_i (no wait)        cfg_wdata_i = max_item_size
//  request   in   in_valid_i / in_ready_o   op_i, item_id_i, item_size_i
//  result    out  out_valid_o / out_ready_i status_o, position_o, entry_count_o
//
// One request at a time; a rejected upsert skips the scan and goes straight to the output register.
// Others scan one entry per cycle from slot 0 to the first id not below the request,
// move the entries above that slot one per cycle, then load the output register.
// Reset empties the table and sets the limit to 64 KiB; no clearing pass is needed.
// A finished request stalls in its last state while the output register is full.
`include "assert_macros.svh"

module sorted_id_index_table_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sidt_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [sidt_pkg::ID_W-1:0]     item_id_i,
  input  logic [sidt_pkg::SIZE_W-1:0]   item_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sidt_pkg::STATUS_W-1:0] status_o,
  output logic [sidt_pkg::POS_W-1:0]    position_o,
  output logic [sidt_pkg::COUNT_W-1:0]  entry_count_o
);
  import sidt_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

  // Control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SIZE_W-1:0] max_size_q, max_size_d;
  logic              pend_q, pend_d;      // a read issued last cycle returns now
  logic              out_valid_q, out_valid_d;

  // Request and working registers
  logic              op_q, op_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [CNT_W-1:0]  scan_q, scan_d;      // next slot to read during the scan
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  rp_q, rp_d;          // shift read pointer
  logic [CNT_W-1:0]  rem_q, rem_d;        // entries still to read for the shift
  status_e           res_status_q, res_status_d;

  // Output register
  status_e            out_status_q, out_status_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;

  // Memory port
  logic             mem_wr_en, mem_rd_en;
  logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
  entry_t           mem_wr_data, mem_rd_data;

  // Scan decision
  logic             scan_stop, scan_end, scan_done, scan_hit;
  logic [CNT_W-1:0] scan_pos;

  sidt_mem #(
    .DEPTH(MAX_ENTRIES)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data)
  );

  // Table is ascending, so the first id not below the request ends the search.
  assign scan_stop = pend_q && (mem_rd_data.id >= id_q);
  assign scan_end  = !pend_q && (scan_q == count_q);
  assign scan_done = scan_stop || scan_end;
  assign scan_hit  = scan_stop && (mem_rd_data.id == id_q);
  assign scan_pos  = scan_stop ? CNT_W'(pend_idx_q) : count_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    max_size_d   = max_size_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    id_d         = id_q;
    size_d       = size_q;
    scan_d       = scan_q;
    pend_idx_d   = pend_idx_q;
    pos_d        = pos_q;
    rp_d         = rp_q;
    rem_d        = rem_q;
    res_status_d = res_status_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_count_d  = out_count_q;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = pos_q[IDX_W-1:0];
    mem_wr_data  = entry_t'{id: id_q, size: size_q};
    mem_rd_en    = 1'b0;
    mem_rd_addr  = scan_q[IDX_W-1:0];
    in_ready_o   = 1'b0;

    if (cfg_we_i) begin
      max_size_d = cfg_wdata_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d   = op_i;
          id_d   = item_id_i;
          size_d = item_size_i;
          scan_d = '0;
          pend_d = 1'b0;
          if (op_i == OP_UPSERT && (item_id_i == '0 || item_size_i == '0 ||
                                    item_size_i > max_size_q)) begin
            res_status_d = STAT_INVALID;
            pos_d        = '0;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (scan_done) begin
          pos_d        = scan_pos;
          res_status_d = STAT_OK;
          pend_d       = 1'b0;
          if (op_q == OP_UPSERT) begin
            if (scan_hit) begin
              // size update in place
              mem_wr_en   = 1'b1;
              mem_wr_addr = scan_pos[IDX_W-1:0];
              state_d     = S_DONE;
            end else if (count_q == FULL_CNT) begin
              res_status_d = STAT_FULL;
              pos_d        = '0;
              state_d      = S_DONE;
            end else begin
              rem_d   = count_q - scan_pos;
              rp_d    = IDX_W'(count_q - CNT_W'(1));
              state_d = S_SHIFT;
            end
          end else begin
            if (scan_hit) begin
              rem_d   = count_q - scan_pos - CNT_W'(1);
              rp_d    = IDX_W'(scan_pos + CNT_W'(1));
              state_d = S_SHIFT;
            end else begin
              res_status_d = STAT_NOT_FOUND;
              pos_d        = '0;
              state_d      = S_DONE;
            end
          end
        end else if (scan_q != count_q) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = scan_q[IDX_W-1:0];
          scan_d      = scan_q + CNT_W'(1);
          pend_d      = 1'b1;
          pend_idx_d  = scan_q[IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
      end

      S_SHIFT: begin
        // Read one slot, write the previous read one slot over. Read and write
        // addresses are always two apart, so no forwarding is needed.
        if (pend_q) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = (op_q == OP_UPSERT) ? pend_idx_q + IDX_W'(1)
                                            : pend_idx_q - IDX_W'(1);
          mem_wr_data = mem_rd_data;
        end
        if (rem_q != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = rp_q;
          rp_d        = (op_q == OP_UPSERT) ? rp_q - IDX_W'(1) : rp_q + IDX_W'(1);
          rem_d       = rem_q - CNT_W'(1);
          pend_d      = 1'b1;
          pend_idx_d  = rp_q;
        end else if (!pend_q) begin
          if (op_q == OP_UPSERT) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_q[IDX_W-1:0];
            count_d     = count_q + CNT_W'(1);
          end else begin
            count_d = count_q - CNT_W'(1);
          end
          state_d = S_DONE;
        end else begin
          pend_d = 1'b0;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = POS_W'(pos_q);
          out_count_d  = COUNT_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      max_size_q  <= MAX_SIZE_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      max_size_q  <= max_size_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    id_q         <= id_d;
    size_q       <= size_d;
    scan_q       <= scan_d;
    pend_idx_q   <= pend_idx_d;
    pos_q        <= pos_d;
    rp_q         <= rp_d;
    rem_q        <= rem_d;
    res_status_q <= res_status_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign position_o    = out_pos_q;
  assign entry_count_o = out_count_q;

  `ASSERT_ALWAYS(a_count_bound, count_q <= FULL_CNT, "entry count above depth")
  `ASSERT_IMPL(a_no_same_slot, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "slot clash")
  `ASSERT_ALWAYS(a_count_at_shift_end, (count_q == $past(count_q)) || ($past(state_q) == S_SHIFT), "count moved")
  `ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != S_IDLE, "request not taken")

endmodule

// ===== sim/sidt_result_checker.sv =====
// Result checker for the sorted id index table: tracks the table, predicts and compares beats.
module sidt_result_checker
  import sidt_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SIZE_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                op_i,
  input  logic [ID_W-1:0]     item_id_i,
  input  logic [SIZE_W-1:0]   item_size_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic [COUNT_W-1:0]  entry_count_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  full_hits_o,
  output int                  peak_count_o
);

  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
  } outcome_t;

  logic [ID_W-1:0]   held_ids   [MAX_ENTRIES];
  logic [SIZE_W-1:0] held_sizes [MAX_ENTRIES];
  int                held_count;
  logic [SIZE_W-1:0] size_limit;
  outcome_t          outcomes_due [$];

  // Applies one request to the shadow table and returns the beat it must produce.
  function automatic outcome_t table_outcome(input logic op, input logic [ID_W-1:0] id,
                                             input logic [SIZE_W-1:0] size);
    outcome_t res;
    int       slot;
    int       i;
    res.status   = STAT_OK;
    res.position = '0;
    slot = MAX_ENTRIES;
    for (i = 0; i < held_count; i++) begin
      if (slot == MAX_ENTRIES && held_ids[i] == id) slot = i;
    end
    if (op == OP_UPSERT) begin
      if (id == '0 || size == '0 || size > size_limit) begin
        res.status = STAT_INVALID;
      end else if (slot < MAX_ENTRIES) begin
        held_sizes[slot] = size;
        res.position = slot[POS_W-1:0];
      end else if (held_count >= MAX_ENTRIES) begin
        res.status = STAT_FULL;
      end else begin
        slot = held_count;
        while (slot > 0 && held_ids[slot-1] > id) begin
          held_ids[slot]   = held_ids[slot-1];
          held_sizes[slot] = held_sizes[slot-1];
          slot--;
        end
        held_ids[slot]   = id;
        held_sizes[slot] = size;
        held_count++;
        res.position = slot[POS_W-1:0];
      end
    end else if (slot == MAX_ENTRIES) begin
      res.status = STAT_NOT_FOUND;
    end else begin
      for (i = slot; i + 1 < held_count; i++) begin
        held_ids[i]   = held_ids[i+1];
        held_sizes[i] = held_sizes[i+1];
      end
      held_count--;
      res.position = slot[POS_W-1:0];
    end
    res.entry_count = held_count[COUNT_W-1:0];
    return res;
  endfunction

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      held_count   = 0;
      size_limit   = MAX_SIZE_RESET;
      outcomes_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      full_hits_o  = 0;
      peak_count_o = 0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        held_ids[i]   = '0;
        held_sizes[i] = '0;
      end
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (outcomes_due.size() == 0) begin
          note_failure($sformatf("result beat with nothing outstanding (status %0d)",
                                 status_i));
        end else begin
          want = outcomes_due.pop_front();
          checked_o++;
          if (status_i !== want.status)
            note_failure($sformatf("status expected %0d, got %0d", want.status, status_i));
          if (position_i !== want.position)
            note_failure($sformatf("position expected %0d, got %0d", want.position,
                                   position_i));
          if (entry_count_i !== want.entry_count)
            note_failure($sformatf("entry count expected %0d, got %0d", want.entry_count,
                                   entry_count_i));
        end
      end
      if (cfg_we_i) size_limit = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        want = table_outcome(op_i, item_id_i, item_size_i);
        if (want.status == STAT_FULL) full_hits_o++;
        if (held_count > peak_count_o) peak_count_o = held_count;
        outcomes_due.push_back(want);
      end
      pending_o = outcomes_due.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the sorted id index table: stimulus, result sink, watchdog and verdict.
module testbench;
  import sidt_pkg::*;

  localparam int MAX_ENTRIES  = 16;
  // The drain wait is longer than the worst request takes.
  localparam int DRAIN_CYCLES = 2 * MAX_ENTRIES + 8;
  // Long receiver hold-off; the watchdog limit must sit well above it.
  localparam int LONG_HOLD    = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int POOL_SIZE    = 24;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_PATTERN,
    SINK_SPARSE
  } sink_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [SIZE_W-1:0]   cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                op_i;
  logic [ID_W-1:0]     item_id_i;
  logic [SIZE_W-1:0]   item_size_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [POS_W-1:0]    position_o;
  logic [COUNT_W-1:0]  entry_count_o;

  int fail_count;
  int pending;
  int checked;
  int full_hits;
  int peak_count;

  // Stimulus bookkeeping; the limit copy only shapes sizes, it predicts nothing.
  int                requests_sent;
  int                limits_used;
  logic [SIZE_W-1:0] limit_now;
  logic [ID_W-1:0]   id_pool [POOL_SIZE];
  bit                hold_request;
  bit                hold_done;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  sorted_id_index_table_top #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .item_id_i     (item_id_i),
    .item_size_i   (item_size_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o)
  );

  sidt_result_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .op_i          (op_i),
    .item_id_i     (item_id_i),
    .item_size_i   (item_size_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .position_i    (position_o),
    .entry_count_i (entry_count_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .full_hits_o   (full_hits),
    .peak_count_o  (peak_count)
  );

  // Offer one request beat at the falling edge and hold it until accepted.
  // Back-to-back calls keep valid high: only the payload changes.
  task automatic send_request(input logic op, input logic [ID_W-1:0] id,
                              input logic [SIZE_W-1:0] size);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    op_i        <= op;
    item_id_i   <= id;
    item_size_i <= size;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Drop valid for a gap whose length is set by n.
  task automatic sender_pause(input int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // The limit register only moves while no request is in the block.
  // Every request yields a beat, so an empty scoreboard means idle; an extra
  // wait then covers the hand-back to the idle state.
  task automatic write_limit(input logic [SIZE_W-1:0] value);
    sender_pause(1);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    limit_now = value;
    limits_used++;
  endtask

  // Mostly ids from a small pool, so that updates, hits on delete and a full
  // table are common; the rest is id zero, the top id and full-range noise.
  task automatic pick_request(input int upsert_pct, output logic op,
                              output logic [ID_W-1:0] id, output logic [SIZE_W-1:0] size);
    int roll;
    op   = ($urandom_range(99) < upsert_pct) ? OP_UPSERT : OP_DELETE;
    roll = $urandom_range(99);
    if (roll < 84)      id = id_pool[$urandom_range(POOL_SIZE - 1)];
    else if (roll < 89) id = '0;
    else if (roll < 92) id = '1;
    else                id = ID_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 68)      size = (limit_now == '0) ? SIZE_W'(1)
                                                 : SIZE_W'(1 + ($urandom % limit_now));
    else if (roll < 76) size = limit_now;
    else if (roll < 83) size = limit_now + 1'b1;
    else if (roll < 88) size = '0;
    else if (roll < 92) size = '1;
    else                size = SIZE_W'($urandom);
  endtask

  // One random phase: new limit, new id pool, bursts of beats with random gaps.
  task automatic run_phase(input logic [SIZE_W-1:0] limit, input int upsert_pct,
                           input int n_items);
    int               sent;
    int               burst;
    int               gap;
    logic             op;
    logic [ID_W-1:0]  id;
    logic [SIZE_W-1:0] size;
    write_limit(limit);
    id_pool[0] = 16'h0001;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(2, 16'hFFFE));
    if (!hold_done) hold_request = 1'b1;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 10);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        pick_request(upsert_pct, op, id, size);
        send_request(op, id, size);
        sent++;
      end
      // Mix of no gap, short gaps and gaps longer than a whole request.
      case ($urandom_range(3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 4);
        2:       gap = $urandom_range(5, 20);
        default: gap = $urandom_range(21, 45);
      endcase
      if (gap > 0) sender_pause(gap);
    end
  endtask

  // Result sink: stalls on patterns of its own, plus one long hold-off once the
  // random part starts, so the output register fills and input ready drops.
  initial begin : result_sink
    sink_mode_e mode;
    int         span;
    int         tick;
    tick        = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request && !hold_done) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end
      mode = sink_mode_e'($urandom_range(3));
      span = $urandom_range(8, 64);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          SINK_OPEN:    out_ready_i <= 1'b1;
          SINK_COIN:    out_ready_i <= ($urandom_range(1) == 1);
          SINK_PATTERN: out_ready_i <= (tick % 5 != 0);
          default:      out_ready_i <= ($urandom_range(4) == 0);
        endcase
      end
    end
  end

  // Watchdog: too many cycles in a row without any beat on either channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 quiet, pending);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] rnd_size;
    requests_sent = 0;
    limits_used   = 0;
    hold_request  = 1'b0;
    hold_done     = 1'b0;
    limit_now     = MAX_SIZE_RESET;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    op_i          = OP_UPSERT;
    item_id_i     = '0;
    item_size_i   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part, at the reset limit of 64 KiB.
    // Rejected arguments: id zero, size zero, size just over the limit, all-ones size.
    send_request(OP_UPSERT, 16'h0000, 17'd5);
    send_request(OP_UPSERT, 16'h0007, 17'd0);
    send_request(OP_UPSERT, 16'h0007, 17'h10001);
    send_request(OP_UPSERT, 16'h0007, 17'h1FFFF);
    // Deletes on an empty table, including id zero.
    send_request(OP_DELETE, 16'h0007, 17'd0);
    send_request(OP_DELETE, 16'h0000, 17'h1FFFF);
    // Top id at the exact limit, then smaller ids landing below it.
    send_request(OP_UPSERT, 16'hFFFF, 17'h10000);
    send_request(OP_UPSERT, 16'h0001, 17'd1);
    send_request(OP_UPSERT, 16'h8000, 17'h0AAAA);
    // Update of a present id.
    send_request(OP_UPSERT, 16'h8000, 17'h0FFFF);
    // Descending ids fill the table, each one shifting the larger entries up.
    for (int i = 0; i < MAX_ENTRIES - 3; i++) begin
      rnd_size = SIZE_W'($urandom_range(1, 17'h10000));
      send_request(OP_UPSERT, ID_W'(16'h7F00 - i * 16'h0500), rnd_size);
    end
    // Full table: absent id refused, present id still updated.
    send_request(OP_UPSERT, 16'h4242, 17'd100);
    send_request(OP_UPSERT, 16'h8000, 17'd2);
    // Deletes from the middle, the bottom and the top.
    send_request(OP_DELETE, 16'h5C00, 17'd0);
    send_request(OP_DELETE, 16'h0001, 17'd0);
    send_request(OP_DELETE, 16'hFFFF, 17'd0);

    // Random part: limits at both extremes and in between, insert-heavy
    // phases to fill the table and delete-heavy ones to drain it.
    run_phase(17'h10000, 75, 80);
    run_phase(17'd1, 55, 40);
    run_phase(17'h1FFFF, 50, 80);
    run_phase(17'd0, 45, 30);
    run_phase(SIZE_W'($urandom_range(2, 17'h1FFFE)), 70, 80);
    run_phase(SIZE_W'($urandom_range(1, 300)), 30, 90);

    sender_pause(1);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run: %0d requests under %0d size limits, %0d result beats checked",
             requests_sent, limits_used + 1, checked);
    $display("run: %0d table-full refusals, peak of %0d entries held", full_hits, peak_count);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
